>>> hdl/s2x_pkg.sv
`default_nettype none

package s2x_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int PIXEL_BITS     = 32;
   localparam int FIELD_BITS     = 32;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = 16;
   localparam int CFG_W_BITS     = 11;
   localparam int W_BITS         = (CFG_W_BITS > COL_BITS + 1) ? CFG_W_BITS : COL_BITS + 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam int BLK_COUNT      = 3;

   localparam int BLK_ABOVE = 0;
   localparam int BLK_LATE  = 1;
   localparam int BLK_FINAL = 2;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [COL_BITS-1:0]  col;
      logic [ROW_BITS-1:0]  row;
      logic                 row_end;
      logic                 sel;
      logic [BLK_COUNT-1:0] mask;
      logic [COL_BITS-1:0]  next_addr;
   } scan_info_type;

endpackage

`default_nettype wire

>>> hdl/s2x_stream_if.sv
`default_nettype none

interface s2x_req_if;
   logic                            valid;
   logic                            ready;
   logic [s2x_pkg::FIELD_BITS-1:0]  pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface s2x_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [s2x_pkg::FIELD_BITS-1:0]  out_top_left;
   logic [s2x_pkg::FIELD_BITS-1:0]  out_top_right;
   logic [s2x_pkg::FIELD_BITS-1:0]  out_bottom_left;
   logic [s2x_pkg::FIELD_BITS-1:0]  out_bottom_right;
   logic [s2x_pkg::COL_BITS-1:0]    src_col;
   logic [s2x_pkg::ROW_BITS-1:0]    src_row;
   logic                            run_last;
   logic                            frame_done;

   modport source (output valid, output out_top_left, output out_top_right,
                   output out_bottom_left, output out_bottom_right, output src_col,
                   output src_row, output run_last, output frame_done, input ready);
   modport sink   (input valid, input out_top_left, input out_top_right,
                   input out_bottom_left, input out_bottom_right, input src_col,
                   input src_row, input run_last, input frame_done, output ready);
endinterface

`default_nettype wire

>>> hdl/scale2x_pixel_upscaler.sv
`default_nettype none

// Scale2x pixel-art upscaler. Source pixels enter in raster order, one per clock, and every
// source pixel yields one 2x2 destination block tagged with its source column and row. Blocks
// of a row are delivered while the following row streams in, so output trails input by one
// row; blocks of the last row trail by one pixel, and the frame's final pixel releases up to
// three blocks. The sustained rate is one pixel per clock unless the output stalls; a pixel
// that releases more than one block holds the input, which happens only on the last row,
// where each pixel from the second column on also releases the late block. Two line stores
// of 1024 words, each read once per transfer, hold the newer and the older source row; the
// store with the older row also takes the incoming pixel, and the two swap roles at each row
// end. They need no clearing after reset. frame_width and frame_height may be written only
// while the block is idle, and a new frame starts at column zero, row zero.
module scale2x_pixel_upscaler (
   input  wire logic                               clock,
   input  wire logic                               reset,
   s2x_req_if.sink                                 req_if,
   s2x_rsp_if.source                               rsp_if,
   input  wire logic                               csr_we,
   input  wire s2x_pkg::csr_index_type             csr_index,
   input  wire logic [s2x_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import s2x_pkg::*;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] tl;
      logic [PIXEL_BITS-1:0] tr;
      logic [PIXEL_BITS-1:0] bl;
      logic [PIXEL_BITS-1:0] br;
   } corner_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] tl;
      logic [FIELD_BITS-1:0] tr;
      logic [FIELD_BITS-1:0] bl;
      logic [FIELD_BITS-1:0] br;
      logic [COL_BITS-1:0]   col;
      logic [ROW_BITS-1:0]   row;
      logic                  run_last;
      logic                  frame_done;
   } rsp_item_type;

   function automatic corner_type scale2x_rule(
      input logic [PIXEL_BITS-1:0] e,
      input logic [PIXEL_BITS-1:0] a,
      input logic [PIXEL_BITS-1:0] b,
      input logic [PIXEL_BITS-1:0] c,
      input logic [PIXEL_BITS-1:0] d
   );
      corner_type r;
      r.tl = (c == a && c != d && a != b) ? a : e;
      r.tr = (a == b && a != c && b != d) ? b : e;
      r.bl = (d == c && d != b && c != a) ? c : e;
      r.br = (b == d && b != a && d != c) ? d : e;
      return r;
   endfunction

   scan_info_type          info;
   logic                   accept;
   logic [PIXEL_BITS-1:0]  pixel;
   logic [PIXEL_BITS-1:0]  rd0;
   logic [PIXEL_BITS-1:0]  rd1;

   logic [BLK_COUNT-1:0]   pend_ff;
   logic [BLK_COUNT-1:0]   pend_in;
   logic [BLK_COUNT-1:0]   pend_rest;
   logic [PIXEL_BITS-1:0]  pix_ff;
   logic [PIXEL_BITS-1:0]  prev1_ff;
   logic [PIXEL_BITS-1:0]  prev2_ff;
   logic [PIXEL_BITS-1:0]  nw_cur_ff;
   logic [PIXEL_BITS-1:0]  nw_prev_ff;
   logic [PIXEL_BITS-1:0]  od_cur_ff;
   logic [COL_BITS-1:0]    col_b_ff;
   logic [ROW_BITS-1:0]    row_b_ff;
   logic                   row_end_b_ff;
   logic                   sel_b_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_item_type           rsp_data_ff;
   rsp_item_type           rsp_data_in;

   logic                   out_free;
   logic                   out_load;
   logic [PIXEL_BITS-1:0]  nw_next;
   logic [PIXEL_BITS-1:0]  pe;
   logic [PIXEL_BITS-1:0]  pa;
   logic [PIXEL_BITS-1:0]  pb;
   logic [PIXEL_BITS-1:0]  pc;
   logic [PIXEL_BITS-1:0]  pd;
   corner_type             corners;

   assign pixel = req_if.pixel_in[PIXEL_BITS-1:0];

   s2x_scan_ctrl u_scan_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .info      (info)
   );

   // Bank sel holds the newer row; the other bank takes the incoming row.
   s2x_line_ram u_bank0 (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (info.next_addr),
      .rd_data (rd0),
      .wr_en   (accept && info.sel),
      .wr_addr (info.col),
      .wr_data (pixel)
   );

   s2x_line_ram u_bank1 (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (info.next_addr),
      .rd_data (rd1),
      .wr_en   (accept && !info.sel),
      .wr_addr (info.col),
      .wr_data (pixel)
   );

   always_comb begin
      pend_rest = pend_ff & (pend_ff - BLK_COUNT'(1));
      out_free  = !rsp_valid_ff || rsp_if.ready;
      out_load  = (pend_ff != '0) && out_free;
   end

   assign req_if.ready = (pend_ff == '0) || ((pend_rest == '0) && out_free);
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      nw_next     = sel_b_ff ? rd1 : rd0;
      rsp_data_in = '0;
      if (pend_ff[BLK_ABOVE]) begin
         pe              = nw_cur_ff;
         pa              = (row_b_ff == ROW_BITS'(1)) ? nw_cur_ff : od_cur_ff;
         pb              = row_end_b_ff ? nw_cur_ff : nw_next;
         pc              = (col_b_ff == '0) ? nw_cur_ff : nw_prev_ff;
         pd              = pix_ff;
         rsp_data_in.col = col_b_ff;
         rsp_data_in.row = row_b_ff - ROW_BITS'(1);
      end else if (pend_ff[BLK_LATE]) begin
         pe              = prev1_ff;
         pa              = (row_b_ff == '0) ? prev1_ff : nw_prev_ff;
         pb              = pix_ff;
         pc              = (col_b_ff == COL_BITS'(1)) ? prev1_ff : prev2_ff;
         pd              = prev1_ff;
         rsp_data_in.col = col_b_ff - COL_BITS'(1);
         rsp_data_in.row = row_b_ff;
      end else begin
         pe                     = pix_ff;
         pa                     = (row_b_ff == '0) ? pix_ff : nw_cur_ff;
         pb                     = pix_ff;
         pc                     = (col_b_ff == '0) ? pix_ff : prev1_ff;
         pd                     = pix_ff;
         rsp_data_in.col        = col_b_ff;
         rsp_data_in.row        = row_b_ff;
         rsp_data_in.frame_done = 1'b1;
      end
      corners              = scale2x_rule(pe, pa, pb, pc, pd);
      rsp_data_in.tl       = FIELD_BITS'(corners.tl);
      rsp_data_in.tr       = FIELD_BITS'(corners.tr);
      rsp_data_in.bl       = FIELD_BITS'(corners.bl);
      rsp_data_in.br       = FIELD_BITS'(corners.br);
      rsp_data_in.run_last = (pend_rest == '0);
   end

   always_comb begin
      pend_in = pend_ff;
      if (out_load) begin
         pend_in = pend_rest;
      end
      if (accept) begin
         pend_in = info.mask;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff       <= pixel;
         prev1_ff     <= pix_ff;
         prev2_ff     <= prev1_ff;
         nw_cur_ff    <= info.sel ? rd1 : rd0;
         nw_prev_ff   <= nw_cur_ff;
         od_cur_ff    <= info.sel ? rd0 : rd1;
         col_b_ff     <= info.col;
         row_b_ff     <= info.row;
         row_end_b_ff <= info.row_end;
         sel_b_ff     <= info.sel;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.out_top_left     = rsp_data_ff.tl;
   assign rsp_if.out_top_right    = rsp_data_ff.tr;
   assign rsp_if.out_bottom_left  = rsp_data_ff.bl;
   assign rsp_if.out_bottom_right = rsp_data_ff.br;
   assign rsp_if.src_col          = rsp_data_ff.col;
   assign rsp_if.src_row          = rsp_data_ff.row;
   assign rsp_if.run_last         = rsp_data_ff.run_last;
   assign rsp_if.frame_done       = rsp_data_ff.frame_done;

endmodule

`default_nettype wire

>>> hdl/s2x_line_ram.sv
`default_nettype none

module s2x_line_ram (
   input  wire logic                            clock,
   input  wire logic                            rd_en,
   input  wire logic [s2x_pkg::COL_BITS-1:0]    rd_addr,
   output      logic [s2x_pkg::PIXEL_BITS-1:0]  rd_data,
   input  wire logic                            wr_en,
   input  wire logic [s2x_pkg::COL_BITS-1:0]    wr_addr,
   input  wire logic [s2x_pkg::PIXEL_BITS-1:0]  wr_data
);
   import s2x_pkg::*;

   logic [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= line_mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/s2x_scan_ctrl.sv
`default_nettype none

module s2x_scan_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire s2x_pkg::csr_index_type             csr_index,
   input  wire logic [s2x_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                               accept,
   output      s2x_pkg::scan_info_type             info
);
   import s2x_pkg::*;

   logic [CFG_W_BITS-1:0] frame_width_ff;
   logic [ROW_BITS-1:0]   frame_height_ff;
   logic [COL_BITS-1:0]   col_ff;
   logic [COL_BITS-1:0]   col_in;
   logic [ROW_BITS-1:0]   row_ff;
   logic [ROW_BITS-1:0]   row_in;
   logic                  sel_ff;
   logic                  sel_in;

   logic [W_BITS-1:0]     width_eff;
   logic [ROW_BITS-1:0]   height_eff;
   logic [COL_BITS:0]     col_plus;
   logic [ROW_BITS:0]     row_plus;
   logic                  row_end;
   logic                  last_row;
   logic                  frame_end;

   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = W_BITS'(1);
      end else if (W_BITS'(frame_width_ff) > W_BITS'(MAX_WIDTH)) begin
         width_eff = W_BITS'(MAX_WIDTH);
      end else begin
         width_eff = W_BITS'(frame_width_ff);
      end
      height_eff = (frame_height_ff == '0) ? ROW_BITS'(1) : frame_height_ff;
      col_plus   = {1'b0, col_ff} + (COL_BITS+1)'(1);
      row_plus   = {1'b0, row_ff} + (ROW_BITS+1)'(1);
      row_end    = W_BITS'(col_plus) >= width_eff;
      last_row   = row_plus >= {1'b0, height_eff};
      frame_end  = last_row && row_end;
   end

   always_comb begin
      info.col              = col_ff;
      info.row              = row_ff;
      info.row_end          = row_end;
      info.sel              = sel_ff;
      info.mask[BLK_ABOVE]  = (row_ff != '0);
      info.mask[BLK_LATE]   = last_row && (col_ff != '0);
      info.mask[BLK_FINAL]  = frame_end;
      info.next_addr        = row_end ? '0 : col_plus[COL_BITS-1:0];
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      sel_in = sel_ff;
      if (accept) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
            sel_in = 1'b0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_plus[ROW_BITS-1:0];
            sel_in = ~sel_ff;
         end else begin
            col_in = col_plus[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_W_BITS'(64);
         frame_height_ff <= ROW_BITS'(32);
         col_ff          <= '0;
         row_ff          <= '0;
         sel_ff          <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         sel_ff <= sel_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  frame_width_ff <= csr_wdata[CFG_W_BITS-1:0];
               end
               CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_wdata[ROW_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

>>> verif/scale2x_pixel_upscaler_tb.sv
`timescale 1ns / 100ps

module scale2x_pixel_upscaler_tb;
   import s2x_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 16;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [31:0] BLACK   = 32'h0000_0000;
   localparam logic [31:0] WHITE   = 32'hFFFF_FFFF;
   localparam logic [31:0] MIDTONE = 32'h5A5A_A5A5;

   typedef struct packed {
      logic [31:0]         top_left;
      logic [31:0]         top_right;
      logic [31:0]         bottom_left;
      logic [31:0]         bottom_right;
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      logic                run_last;
      logic                frame_done;
   } epx_quad_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   s2x_req_if req_bus ();
   s2x_rsp_if rsp_bus ();

   scale2x_pixel_upscaler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the scaler state.
   bit [31:0]   line_store [2][MAX_WIDTH];
   int unsigned scan_col;
   int unsigned scan_row;
   bit          bank_sel;
   logic [31:0] last_pix;
   logic [31:0] prior_pix;
   int unsigned cfg_width;
   int unsigned cfg_height;

   epx_quad_type pending_quads[$];
   int           mismatch_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   logic [31:0]  palette [4];
   int           palette_size;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("scale2x_pixel_upscaler regression: fail");
      $finish;
   end

   function automatic epx_quad_type scale_quad(input logic [31:0] e, input logic [31:0] a,
                                               input logic [31:0] b, input logic [31:0] c,
                                               input logic [31:0] d, input int unsigned col,
                                               input int unsigned row, input bit done);
      epx_quad_type q;
      q.top_left     = (c == a && c != d && a != b) ? a : e;
      q.top_right    = (a == b && a != c && b != d) ? b : e;
      q.bottom_left  = (d == c && d != b && c != a) ? c : e;
      q.bottom_right = (b == d && b != a && d != c) ? d : e;
      q.col          = COL_BITS'(col);
      q.row          = ROW_BITS'(row);
      q.run_last     = 1'b0;
      q.frame_done   = done;
      return q;
   endfunction

   task automatic predict_quads(input logic [31:0] pix);
      int unsigned  w, h, x, y;
      bit           last_row, row_end, frame_end;
      logic [31:0]  e, a, b, c;
      epx_quad_type quads [3];
      int           n;
      n = 0;
      w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      x = scan_col;
      y = scan_row;
      last_row  = (y + 1 >= h);
      row_end   = (x + 1 >= w);
      frame_end = last_row && row_end;
      if (y >= 1) begin
         e = line_store[!bank_sel][x];
         a = (y == 1) ? e : line_store[bank_sel][x];
         b = row_end ? e : line_store[!bank_sel][x + 1];
         c = (x == 0) ? e : line_store[!bank_sel][x - 1];
         quads[n] = scale_quad(e, a, b, c, pix, x, y - 1, 1'b0);
         n++;
      end
      if (last_row && x >= 1) begin
         e = last_pix;
         a = (y == 0) ? e : line_store[!bank_sel][x - 1];
         c = (x == 1) ? e : prior_pix;
         quads[n] = scale_quad(e, a, pix, c, e, x - 1, y, 1'b0);
         n++;
      end
      if (frame_end) begin
         a = (y == 0) ? pix : line_store[!bank_sel][x];
         c = (x == 0) ? pix : last_pix;
         quads[n] = scale_quad(pix, a, pix, c, pix, x, y, 1'b1);
         n++;
      end
      for (int i = 0; i < n; i++) begin
         quads[i].run_last = (i == n - 1);
         pending_quads.push_back(quads[i]);
      end
      line_store[bank_sel][x] = pix;
      prior_pix = last_pix;
      last_pix  = pix;
      if (frame_end) begin
         scan_col = 0;
         scan_row = 0;
         bank_sel = 1'b0;
      end else if (row_end) begin
         scan_col = 0;
         scan_row = (y + 1) & 16'hFFFF;
         bank_sel = ~bank_sel;
      end else begin
         scan_col = x + 1;
      end
   endtask

   function automatic string quad_text(input epx_quad_type q);
      return $sformatf("%h %h %h %h col %0d row %0d last %0b done %0b", q.top_left,
                       q.top_right, q.bottom_left, q.bottom_right, q.col, q.row,
                       q.run_last, q.frame_done);
   endfunction

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_quads
      epx_quad_type got;
      epx_quad_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.top_left     = rsp_bus.out_top_left;
         got.top_right    = rsp_bus.out_top_right;
         got.bottom_left  = rsp_bus.out_bottom_left;
         got.bottom_right = rsp_bus.out_bottom_right;
         got.col          = rsp_bus.src_col;
         got.row          = rsp_bus.src_row;
         got.run_last     = rsp_bus.run_last;
         got.frame_done   = rsp_bus.frame_done;
         if (pending_quads.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("%0t: unexpected block %s", $realtime, quad_text(got));
            mismatch_count++;
         end else begin
            want = pending_quads.pop_front();
            if (got.top_left !== want.top_left || got.top_right !== want.top_right ||
                got.bottom_left !== want.bottom_left ||
                got.bottom_right !== want.bottom_right || got.col !== want.col ||
                got.row !== want.row || got.run_last !== want.run_last ||
                got.frame_done !== want.frame_done) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("%0t: block mismatch", $realtime);
                  $display("   expected %s", quad_text(want));
                  $display("   actual   %s", quad_text(got));
               end
               mismatch_count++;
            end
         end
      end
   end

   // Entered just after a falling edge, and returns just after one.
   task automatic send_pixel(input logic [31:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.pixel_in <= pix;
      predict_quads(pix);
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_quads.size() != 0) @(negedge clock);
   endtask

   task automatic set_geometry(input int unsigned width, input int unsigned height);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= CSR_DATA_BITS'(width);
      cfg_width  = width & 11'h7FF;
      @(negedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= CSR_DATA_BITS'(height);
      cfg_height = height & 16'hFFFF;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic new_palette();
      int r;
      palette_size = $urandom_range(2, 4);
      for (int i = 0; i < 4; i++) begin
         r = $urandom_range(9);
         palette[i] = (r == 0) ? BLACK : ((r == 1) ? WHITE : $urandom);
      end
   endtask

   function automatic logic [31:0] pick_pixel();
      if ($urandom_range(99) < 15)
         return $urandom;
      return palette[$urandom_range(palette_size - 1)];
   endfunction

   task automatic test_degenerate_geometry();
      set_geometry(0, 0);
      send_pixel(BLACK);
      set_geometry(0, 3);
      send_pixel(WHITE);
      send_pixel(BLACK);
      send_pixel(MIDTONE);
   endtask

   task automatic test_corner_rules();
      logic [31:0] left_up [9];
      logic [31:0] right_up [9];
      left_up  = '{MIDTONE, WHITE, MIDTONE, WHITE, BLACK, MIDTONE, MIDTONE, MIDTONE, MIDTONE};
      right_up = '{BLACK, WHITE, BLACK, MIDTONE, BLACK, WHITE, BLACK, MIDTONE, BLACK};
      set_geometry(3, 3);
      foreach (left_up[i]) send_pixel(left_up[i]);
      set_geometry(3, 3);
      foreach (right_up[i]) send_pixel(right_up[i]);
   endtask

   task automatic test_random_frames(input int target);
      int sent, frames, w, h, eff_w, eff_h, stall_at;
      sent   = 0;
      frames = 0;
      while (sent < target) begin
         case ($urandom_range(19))
            0:       w = 0;
            1:       w = $urandom_range(13, 40);
            default: w = $urandom_range(1, 8);
         endcase
         h     = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
         eff_w = (w == 0) ? 1 : w;
         eff_h = (h == 0) ? 1 : h;
         // The sender holds off until every block is out at least once per test.
         stall_at = (frames == 0 || $urandom_range(2) == 0) ?
                    $urandom_range(eff_w * eff_h - 1) : -1;
         new_palette();
         set_geometry(w, h);
         for (int i = 0; i < eff_w * eff_h; i++) begin
            if (i == stall_at)
               wait_drained();
            send_pixel(pick_pixel());
         end
         sent += eff_w * eff_h;
         frames++;
      end
   endtask

   task automatic test_extreme_geometry();
      new_palette();
      set_geometry(1, 12);
      for (int i = 0; i < 12; i++) send_pixel(pick_pixel());
      set_geometry(24, 1);
      for (int i = 0; i < 24; i++) send_pixel(pick_pixel());
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_FRAME_WIDTH;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.pixel_in = '0;
      rsp_bus.ready    = 1'b0;
      scan_col         = 0;
      scan_row         = 0;
      bank_sel         = 1'b0;
      last_pix         = '0;
      prior_pix        = '0;
      cfg_width        = 64;
      cfg_height       = 32;
      mismatch_count   = 0;
      send_idle_pct    = 38;
      recv_idle_pct    = 88;
      palette          = '{BLACK, WHITE, MIDTONE, BLACK};
      palette_size     = 2;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_degenerate_geometry();
      test_corner_rules();
      test_random_frames(70);

      send_idle_pct = 88;
      recv_idle_pct = 38;
      test_random_frames(70);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_extreme_geometry();

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_quads.size() == 0)
         $display("scale2x_pixel_upscaler regression: pass");
      else
         $display("scale2x_pixel_upscaler regression: fail");
      $finish;
   end

endmodule
